FILE: rtl/lavm_pkg.sv
// lavm_pkg: shared types and constants for the look-at view matrix builder.
// Holds the request and response item structs and the fixed-point widths.
// No dependencies.
package lavm_pkg;

   localparam int WORD_W    = 32;          // width of every item field
   localparam int VEC_W     = 3 * WORD_W;  // one packed three-component vector
   localparam int UNIT_BITS = 30;          // fraction bits of a unit component

   typedef logic [2:0][WORD_W-1:0] vec3_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] eye_x;
      logic signed [WORD_W-1:0] eye_y;
      logic signed [WORD_W-1:0] eye_z;
      logic signed [WORD_W-1:0] aim_x;
      logic signed [WORD_W-1:0] aim_y;
      logic signed [WORD_W-1:0] aim_z;
      logic signed [WORD_W-1:0] hint_x;
      logic signed [WORD_W-1:0] hint_y;
      logic signed [WORD_W-1:0] hint_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] right_x;
      logic signed [WORD_W-1:0] right_y;
      logic signed [WORD_W-1:0] right_z;
      logic signed [WORD_W-1:0] up_x;
      logic signed [WORD_W-1:0] up_y;
      logic signed [WORD_W-1:0] up_z;
      logic signed [WORD_W-1:0] back_x;
      logic signed [WORD_W-1:0] back_y;
      logic signed [WORD_W-1:0] back_z;
      logic signed [WORD_W-1:0] shift_x;
      logic signed [WORD_W-1:0] shift_y;
      logic signed [WORD_W-1:0] shift_z;
   } rsp_type;

endpackage

FILE: rtl/lavm_norm.sv
// lavm_norm: pipelined normalizer of a signed three-component vector to Q2.30.
// Scale search, squares, digit-pair square root and two-bit-a-stage dividers.
// Depends on lavm_pkg.
module lavm_norm #(
   parameter int IN_W   = 64,
   parameter int SIDE_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [2:0][IN_W-1:0]   in_vec,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output lavm_pkg::vec3_type     out_vec,
   output logic [SIDE_W-1:0]      out_side
);
   import lavm_pkg::*;

   localparam int MAG_BITS  = UNIT_BITS + 1;
   localparam int GROUPS    = (IN_W + 7) / 8;
   localparam int PAD_W     = GROUPS * 8;
   localparam int LW        = $clog2(IN_W + 1);
   localparam int SQ_W      = 2 * MAG_BITS;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 4;
   localparam int SQ_STEPS  = 2;
   localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
   localparam int DVD_W     = 1 + MAG_BITS + UNIT_BITS;
   localparam int DRM_W     = ROOT_W + 1;
   localparam int DV_STEPS  = 2;
   localparam int DV_STAGES = ROOT_W / DV_STEPS;

   typedef struct packed {
      logic [2:0][MAG_BITS-1:0] m;
      logic [2:0]               sgn;
      logic                     zero;
      logic [SIDE_W-1:0]        side;
   } hold_type;

   // magnitude stage
   logic                   a_v_ff;
   logic [2:0][IN_W-1:0]   a_mag_ff, a_mag_in;
   logic [2:0]             a_sgn_ff;
   logic [SIDE_W-1:0]      a_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = in_vec[i][IN_W-1] ? IN_W'(0) - in_vec[i] : in_vec[i];
      end
   end

   // group scan stage
   logic                   b_v_ff;
   logic [2:0][IN_W-1:0]   b_mag_ff;
   logic [2:0]             b_sgn_ff;
   logic [SIDE_W-1:0]      b_side_ff;
   logic [GROUPS-1:0]      b_nz_ff, b_nz_in;
   logic [GROUPS-1:0][2:0] b_pos_ff, b_pos_in;

   always_comb begin
      logic [PAD_W-1:0] pad;
      logic [7:0]       grp;
      pad = PAD_W'(a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2]);
      grp = '0;
      for (int g = 0; g < GROUPS; g++) begin
         grp = pad[g*8 +: 8];
         b_nz_in[g] = |grp;
         b_pos_in[g] = '0;
         for (int k = 0; k < 8; k++) begin
            if (grp[k]) begin
               b_pos_in[g] = 3'(k);
            end
         end
      end
   end

   // shift amount stage
   logic                   c_v_ff;
   logic [2:0][IN_W-1:0]   c_mag_ff;
   logic [2:0]             c_sgn_ff;
   logic [SIDE_W-1:0]      c_side_ff;
   logic [LW-1:0]          c_rsh_ff, c_rsh_in, c_lsh_ff, c_lsh_in;
   logic                   c_zero_ff, c_zero_in;

   always_comb begin
      logic [LW-1:0] len_v;
      len_v = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (b_nz_ff[g]) begin
            len_v = LW'(g * 8) + LW'(b_pos_ff[g]) + LW'(1);
         end
      end
      if (len_v >= LW'(MAG_BITS)) begin
         c_rsh_in = len_v - LW'(MAG_BITS);
         c_lsh_in = '0;
      end else begin
         c_rsh_in = '0;
         c_lsh_in = LW'(MAG_BITS) - len_v;
      end
      c_zero_in = (len_v == '0);
   end

   // scale stage
   logic     d_v_ff;
   hold_type d_hold_ff, d_hold_in;

   always_comb begin
      logic [IN_W-1:0] sh;
      sh = '0;
      d_hold_in.sgn  = c_sgn_ff;
      d_hold_in.zero = c_zero_ff;
      d_hold_in.side = c_side_ff;
      for (int i = 0; i < 3; i++) begin
         sh = c_mag_ff[i] >> c_rsh_ff;
         d_hold_in.m[i] = sh[MAG_BITS-1:0] << c_lsh_ff;
      end
   end

   // square stage
   logic                 e_v_ff;
   hold_type             e_hold_ff;
   logic [2:0][SQ_W-1:0] e_sq_ff, e_sq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_sq_in[i] = SQ_W'(d_hold_ff.m[i]) * SQ_W'(d_hold_ff.m[i]);
      end
   end

   // square root: entry 0 holds the sum, each later entry two root bits
   logic [SQ_STAGES:0] sq_v_ff;
   logic [SUM_W-1:0]   sq_n_ff    [SQ_STAGES+1];
   logic [SUM_W-1:0]   sq_n_in    [SQ_STAGES+1];
   logic [REM_W-1:0]   sq_rem_ff  [SQ_STAGES+1];
   logic [REM_W-1:0]   sq_rem_in  [SQ_STAGES+1];
   logic [ROOT_W-1:0]  sq_root_ff [SQ_STAGES+1];
   logic [ROOT_W-1:0]  sq_root_in [SQ_STAGES+1];
   hold_type           sq_hold_ff [SQ_STAGES+1];

   always_comb begin
      logic [SUM_W-1:0]  n_v;
      logic [REM_W-1:0]  rem_v;
      logic [ROOT_W-1:0] root_v;
      logic [ROOT_W+1:0] trial;
      n_v = '0;
      rem_v = '0;
      root_v = '0;
      trial = '0;
      sq_n_in[0]    = SUM_W'(e_sq_ff[0]) + SUM_W'(e_sq_ff[1]) + SUM_W'(e_sq_ff[2]);
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      for (int s = 1; s <= SQ_STAGES; s++) begin
         n_v    = sq_n_ff[s-1];
         rem_v  = sq_rem_ff[s-1];
         root_v = sq_root_ff[s-1];
         for (int j = 0; j < SQ_STEPS; j++) begin
            rem_v = {rem_v[REM_W-3:0], n_v[SUM_W-1 -: 2]};
            n_v   = n_v << 2;
            trial = {root_v, 2'b01};
            if (rem_v >= REM_W'(trial)) begin
               rem_v  = rem_v - REM_W'(trial);
               root_v = {root_v[ROOT_W-2:0], 1'b1};
            end else begin
               root_v = {root_v[ROOT_W-2:0], 1'b0};
            end
         end
         sq_n_in[s]    = n_v;
         sq_rem_in[s]  = rem_v;
         sq_root_in[s] = root_v;
      end
   end

   // dividers: entry 0 holds the rounded dividend, each later entry two quotient bits
   logic [DV_STAGES:0]        dv_v_ff;
   logic [2:0][DRM_W-1:0]     dv_rem_ff [DV_STAGES+1];
   logic [2:0][DRM_W-1:0]     dv_rem_in [DV_STAGES+1];
   logic [2:0][ROOT_W-1:0]    dv_qd_ff  [DV_STAGES+1];
   logic [2:0][ROOT_W-1:0]    dv_qd_in  [DV_STAGES+1];
   logic [ROOT_W-1:0]         dv_len_ff [DV_STAGES+1];
   hold_type                  dv_hold_ff[DV_STAGES+1];

   always_comb begin
      logic [DVD_W-1:0]  dvd;
      logic [DRM_W-1:0]  rem_v;
      logic [ROOT_W-1:0] qd_v;
      logic [ROOT_W-1:0] len_v;
      dvd = '0;
      rem_v = '0;
      qd_v = '0;
      len_v = sq_root_ff[SQ_STAGES];
      for (int i = 0; i < 3; i++) begin
         dvd = {1'b0, sq_hold_ff[SQ_STAGES].m[i], {UNIT_BITS{1'b0}}}
               + DVD_W'(len_v[ROOT_W-1:1]);
         dv_rem_in[0][i] = DRM_W'(dvd[DVD_W-1:ROOT_W]);
         dv_qd_in[0][i]  = dvd[ROOT_W-1:0];
      end
      for (int s = 1; s <= DV_STAGES; s++) begin
         for (int i = 0; i < 3; i++) begin
            rem_v = dv_rem_ff[s-1][i];
            qd_v  = dv_qd_ff[s-1][i];
            for (int j = 0; j < DV_STEPS; j++) begin
               rem_v = {rem_v[DRM_W-2:0], qd_v[ROOT_W-1]};
               qd_v  = qd_v << 1;
               if (rem_v >= DRM_W'(dv_len_ff[s-1])) begin
                  rem_v   = rem_v - DRM_W'(dv_len_ff[s-1]);
                  qd_v[0] = 1'b1;
               end
            end
            dv_rem_in[s][i] = rem_v;
            dv_qd_in[s][i]  = qd_v;
         end
      end
   end

   // sign and zero-vector stage
   logic              out_v_ff;
   vec3_type          out_vec_ff, out_vec_in;
   logic [SIDE_W-1:0] out_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_hold_ff[DV_STAGES].zero) begin
            out_vec_in[i] = '0;
         end else if (dv_hold_ff[DV_STAGES].sgn[i]) begin
            out_vec_in[i] = WORD_W'(0) - WORD_W'(dv_qd_ff[DV_STAGES][i]);
         end else begin
            out_vec_in[i] = WORD_W'(dv_qd_ff[DV_STAGES][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         d_v_ff   <= 1'b0;
         e_v_ff   <= 1'b0;
         sq_v_ff  <= '0;
         dv_v_ff  <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff   <= in_valid;
         b_v_ff   <= a_v_ff;
         c_v_ff   <= b_v_ff;
         d_v_ff   <= c_v_ff;
         e_v_ff   <= d_v_ff;
         sq_v_ff  <= {sq_v_ff[SQ_STAGES-1:0], e_v_ff};
         dv_v_ff  <= {dv_v_ff[DV_STAGES-1:0], sq_v_ff[SQ_STAGES]};
         out_v_ff <= dv_v_ff[DV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff  <= a_mag_in;
         for (int i = 0; i < 3; i++) begin
            a_sgn_ff[i] <= in_vec[i][IN_W-1];
         end
         a_side_ff <= in_side;
         b_mag_ff  <= a_mag_ff;
         b_sgn_ff  <= a_sgn_ff;
         b_side_ff <= a_side_ff;
         b_nz_ff   <= b_nz_in;
         b_pos_ff  <= b_pos_in;
         c_mag_ff  <= b_mag_ff;
         c_sgn_ff  <= b_sgn_ff;
         c_side_ff <= b_side_ff;
         c_rsh_ff  <= c_rsh_in;
         c_lsh_ff  <= c_lsh_in;
         c_zero_ff <= c_zero_in;
         d_hold_ff <= d_hold_in;
         e_hold_ff <= d_hold_ff;
         e_sq_ff   <= e_sq_in;
         sq_hold_ff[0] <= e_hold_ff;
         for (int s = 0; s <= SQ_STAGES; s++) begin
            sq_n_ff[s]    <= sq_n_in[s];
            sq_rem_ff[s]  <= sq_rem_in[s];
            sq_root_ff[s] <= sq_root_in[s];
         end
         for (int s = 1; s <= SQ_STAGES; s++) begin
            sq_hold_ff[s] <= sq_hold_ff[s-1];
         end
         dv_hold_ff[0] <= sq_hold_ff[SQ_STAGES];
         dv_len_ff[0]  <= sq_root_ff[SQ_STAGES];
         for (int s = 0; s <= DV_STAGES; s++) begin
            dv_rem_ff[s] <= dv_rem_in[s];
            dv_qd_ff[s]  <= dv_qd_in[s];
         end
         for (int s = 1; s <= DV_STAGES; s++) begin
            dv_hold_ff[s] <= dv_hold_ff[s-1];
            dv_len_ff[s]  <= dv_len_ff[s-1];
         end
         out_vec_ff  <= out_vec_in;
         out_side_ff <= dv_hold_ff[DV_STAGES].side;
      end
   end

   assign out_valid = out_v_ff;
   assign out_vec   = out_vec_ff;
   assign out_side  = out_side_ff;

endmodule

FILE: rtl/look_at_view_matrix_top.sv
// look_at_view_matrix_top: fully pipelined look-at view basis and translation.
// Instantiates three lavm_norm normalizers; depends on lavm_pkg.
//
// The block takes one view per clock (eye, target, up hint, all signed Q16.16)
// and returns right, up and back (negated forward) as Q2.30 unit vectors plus
// the three saturated Q16.16 translation terms -right.eye, -up.eye and
// forward.eye. Every stage advances together, and throughput is one item per
// cycle as long as the result side does not stall. Each item passes through
// the three chained normalizers (each with a 16-stage square root that retires
// two root bits per stage and 16-stage dividers that retire two quotient bits
// per stage), two cross-product stages ahead of each of the later two and
// four stages for the dot products, rounding and saturation. When rsp_stall
// holds back a waiting result, the whole pipeline freezes and req_stall rises
// in the same cycle, so nothing is dropped or repeated. A zero-length forward
// vector gives all-zero outputs; an up hint parallel to forward gives zero
// right and up vectors.
module look_at_view_matrix_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lavm_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lavm_pkg::rsp_type rsp_item
);
   import lavm_pkg::*;

   localparam int DIFF_W = WORD_W + 1;
   localparam int PROD_W = 2 * WORD_W;
   localparam int RND_W  = PROD_W - UNIT_BITS;
   localparam logic [2:0] NEG_ROW = 3'b011;   // right and up terms are negated
   localparam logic [RND_W-1:0] POS_LIMIT = RND_W'(32'h7FFF_FFFF);
   localparam logic [RND_W-1:0] NEG_LIMIT = RND_W'(33'h1_0000_0000) >> 1;
   localparam logic [RND_W-1:0] RND_HALF  = RND_W'(1);
   localparam logic signed [WORD_W-1:0] UNIT_ONE = WORD_W'(1) << UNIT_BITS;

   // global advance: freeze everything while a finished result waits
   logic pipe_en;
   assign pipe_en   = !(rsp_valid && rsp_stall);
   assign req_stall = !pipe_en;

   // input stage: form target minus eye at full 33-bit width
   vec3_type              req_eye, req_hint, req_aim;
   logic                  s0_v_ff;
   logic [2:0][DIFF_W-1:0] s0_diff_ff, s0_diff_in;
   logic [2*VEC_W-1:0]    s0_side_ff;

   assign req_eye  = {req_item.eye_z, req_item.eye_y, req_item.eye_x};
   assign req_aim  = {req_item.aim_z, req_item.aim_y, req_item.aim_x};
   assign req_hint = {req_item.hint_z, req_item.hint_y, req_item.hint_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s0_diff_in[i] = {req_aim[i][WORD_W-1], req_aim[i]}
                         - {req_eye[i][WORD_W-1], req_eye[i]};
      end
   end

   // forward = normalize(aim - eye); carry hint and eye alongside
   logic               n1_v;
   vec3_type           n1_fwd, n1_hint, n1_eye;
   logic [2*VEC_W-1:0] n1_side;

   lavm_norm #(
      .IN_W   (DIFF_W),
      .SIDE_W (2 * VEC_W)
   ) u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s0_v_ff),
      .in_vec    (s0_diff_ff),
      .in_side   (s0_side_ff),
      .out_valid (n1_v),
      .out_vec   (n1_fwd),
      .out_side  (n1_side)
   );

   assign n1_hint = n1_side[2*VEC_W-1:VEC_W];
   assign n1_eye  = n1_side[VEC_W-1:0];

   // forward x hint: partial products, then differences
   logic                     c1_v_ff;
   logic signed [PROD_W-1:0] c1_prod_ff [6];
   logic signed [PROD_W-1:0] c1_prod_in [6];
   vec3_type                 c1_fwd_ff, c1_eye_ff;

   always_comb begin
      c1_prod_in[0] = $signed(n1_fwd[1]) * $signed(n1_hint[2]);
      c1_prod_in[1] = $signed(n1_fwd[2]) * $signed(n1_hint[1]);
      c1_prod_in[2] = $signed(n1_fwd[2]) * $signed(n1_hint[0]);
      c1_prod_in[3] = $signed(n1_fwd[0]) * $signed(n1_hint[2]);
      c1_prod_in[4] = $signed(n1_fwd[0]) * $signed(n1_hint[1]);
      c1_prod_in[5] = $signed(n1_fwd[1]) * $signed(n1_hint[0]);
   end

   logic                   c2_v_ff;
   logic [2:0][PROD_W-1:0] c2_cross_ff, c2_cross_in;
   vec3_type               c2_fwd_ff, c2_eye_ff;

   always_comb begin
      c2_cross_in[0] = c1_prod_ff[0] - c1_prod_ff[1];
      c2_cross_in[1] = c1_prod_ff[2] - c1_prod_ff[3];
      c2_cross_in[2] = c1_prod_ff[4] - c1_prod_ff[5];
   end

   // right = normalize(forward x hint)
   logic               n2_v;
   vec3_type           n2_rgt, n2_fwd, n2_eye;
   logic [2*VEC_W-1:0] n2_side;

   lavm_norm #(
      .IN_W   (PROD_W),
      .SIDE_W (2 * VEC_W)
   ) u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (c2_v_ff),
      .in_vec    (c2_cross_ff),
      .in_side   ({c2_fwd_ff, c2_eye_ff}),
      .out_valid (n2_v),
      .out_vec   (n2_rgt),
      .out_side  (n2_side)
   );

   assign n2_fwd = n2_side[2*VEC_W-1:VEC_W];
   assign n2_eye = n2_side[VEC_W-1:0];

   // right x forward
   logic                     c3_v_ff;
   logic signed [PROD_W-1:0] c3_prod_ff [6];
   logic signed [PROD_W-1:0] c3_prod_in [6];
   vec3_type                 c3_rgt_ff, c3_fwd_ff, c3_eye_ff;

   always_comb begin
      c3_prod_in[0] = $signed(n2_rgt[1]) * $signed(n2_fwd[2]);
      c3_prod_in[1] = $signed(n2_rgt[2]) * $signed(n2_fwd[1]);
      c3_prod_in[2] = $signed(n2_rgt[2]) * $signed(n2_fwd[0]);
      c3_prod_in[3] = $signed(n2_rgt[0]) * $signed(n2_fwd[2]);
      c3_prod_in[4] = $signed(n2_rgt[0]) * $signed(n2_fwd[1]);
      c3_prod_in[5] = $signed(n2_rgt[1]) * $signed(n2_fwd[0]);
   end

   logic                   c4_v_ff;
   logic [2:0][PROD_W-1:0] c4_cross_ff, c4_cross_in;
   vec3_type               c4_rgt_ff, c4_fwd_ff, c4_eye_ff;

   always_comb begin
      c4_cross_in[0] = c3_prod_ff[0] - c3_prod_ff[1];
      c4_cross_in[1] = c3_prod_ff[2] - c3_prod_ff[3];
      c4_cross_in[2] = c3_prod_ff[4] - c3_prod_ff[5];
   end

   // up = normalize(right x forward)
   logic               n3_v;
   vec3_type           n3_up;
   vec3_type           n3_basis [3];   // right, up, forward
   vec3_type           n3_eye;
   logic [3*VEC_W-1:0] n3_side;

   lavm_norm #(
      .IN_W   (PROD_W),
      .SIDE_W (3 * VEC_W)
   ) u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (c4_v_ff),
      .in_vec    (c4_cross_ff),
      .in_side   ({c4_rgt_ff, c4_fwd_ff, c4_eye_ff}),
      .out_valid (n3_v),
      .out_vec   (n3_up),
      .out_side  (n3_side)
   );

   assign n3_basis[0] = n3_side[3*VEC_W-1:2*VEC_W];
   assign n3_basis[1] = n3_up;
   assign n3_basis[2] = n3_side[2*VEC_W-1:VEC_W];
   assign n3_eye      = n3_side[VEC_W-1:0];

   // dot products with the eye: products, sums, round, saturate
   logic                     d1_v_ff;
   logic signed [PROD_W-1:0] d1_prod_ff [3][3];
   logic signed [PROD_W-1:0] d1_prod_in [3][3];
   vec3_type                 d1_basis_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            d1_prod_in[k][i] = $signed(n3_basis[k][i]) * $signed(n3_eye[i]);
         end
      end
   end

   logic                     d2_v_ff;
   logic signed [PROD_W-1:0] d2_sum_ff [3];
   logic signed [PROD_W-1:0] d2_sum_in [3];
   vec3_type                 d2_basis_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d2_sum_in[k] = d1_prod_ff[k][0] + d1_prod_ff[k][1] + d1_prod_ff[k][2];
      end
   end

   // round the magnitude half up at the unit point; fold sign and negation
   logic                  d3_v_ff;
   logic [2:0][RND_W-1:0] d3_rnd_ff, d3_rnd_in;
   logic [2:0]            d3_neg_ff, d3_neg_in;
   vec3_type              d3_basis_ff [3];

   always_comb begin
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] half;
      mag  = '0;
      half = PROD_W'(1) << (UNIT_BITS - 1);
      for (int k = 0; k < 3; k++) begin
         mag = d2_sum_ff[k][PROD_W-1] ? PROD_W'(0) - PROD_W'(d2_sum_ff[k])
                                      : PROD_W'(d2_sum_ff[k]);
         mag = mag + half;
         d3_rnd_in[k] = mag[PROD_W-1:UNIT_BITS];
         d3_neg_in[k] = d2_sum_ff[k][PROD_W-1] ^ NEG_ROW[k];
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_item_ff, rsp_item_in;
   logic [2:0][WORD_W-1:0] shift_v;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (d3_neg_ff[k]) begin
            if (d3_rnd_ff[k] > NEG_LIMIT) begin
               shift_v[k] = {1'b1, {(WORD_W-1){1'b0}}};
            end else begin
               shift_v[k] = WORD_W'(RND_W'(0) - d3_rnd_ff[k]);
            end
         end else begin
            if (d3_rnd_ff[k] > POS_LIMIT) begin
               shift_v[k] = {1'b0, {(WORD_W-1){1'b1}}};
            end else begin
               shift_v[k] = d3_rnd_ff[k][WORD_W-1:0] + (RND_HALF[WORD_W-1:0] & '0);
            end
         end
      end
      rsp_item_in.right_x = d3_basis_ff[0][0];
      rsp_item_in.right_y = d3_basis_ff[0][1];
      rsp_item_in.right_z = d3_basis_ff[0][2];
      rsp_item_in.up_x    = d3_basis_ff[1][0];
      rsp_item_in.up_y    = d3_basis_ff[1][1];
      rsp_item_in.up_z    = d3_basis_ff[1][2];
      rsp_item_in.back_x  = WORD_W'(0) - d3_basis_ff[2][0];
      rsp_item_in.back_y  = WORD_W'(0) - d3_basis_ff[2][1];
      rsp_item_in.back_z  = WORD_W'(0) - d3_basis_ff[2][2];
      rsp_item_in.shift_x = shift_v[0];
      rsp_item_in.shift_y = shift_v[1];
      rsp_item_in.shift_z = shift_v[2];
   end

   // valid bits: advance together, clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff      <= 1'b0;
         c1_v_ff      <= 1'b0;
         c2_v_ff      <= 1'b0;
         c3_v_ff      <= 1'b0;
         c4_v_ff      <= 1'b0;
         d1_v_ff      <= 1'b0;
         d2_v_ff      <= 1'b0;
         d3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_v_ff      <= req_valid;
         c1_v_ff      <= n1_v;
         c2_v_ff      <= c1_v_ff;
         c3_v_ff      <= n2_v;
         c4_v_ff      <= c3_v_ff;
         d1_v_ff      <= n3_v;
         d2_v_ff      <= d1_v_ff;
         d3_v_ff      <= d2_v_ff;
         rsp_valid_ff <= d3_v_ff;
      end
   end

   // payload: hold while frozen
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_diff_ff  <= s0_diff_in;
         s0_side_ff  <= {req_hint, req_eye};
         c1_prod_ff  <= c1_prod_in;
         c1_fwd_ff   <= n1_fwd;
         c1_eye_ff   <= n1_eye;
         c2_cross_ff <= c2_cross_in;
         c2_fwd_ff   <= c1_fwd_ff;
         c2_eye_ff   <= c1_eye_ff;
         c3_prod_ff  <= c3_prod_in;
         c3_rgt_ff   <= n2_rgt;
         c3_fwd_ff   <= n2_fwd;
         c3_eye_ff   <= n2_eye;
         c4_cross_ff <= c4_cross_in;
         c4_rgt_ff   <= c3_rgt_ff;
         c4_fwd_ff   <= c3_fwd_ff;
         c4_eye_ff   <= c3_eye_ff;
         d1_prod_ff  <= d1_prod_in;
         d1_basis_ff <= n3_basis;
         d2_sum_ff   <= d2_sum_in;
         d2_basis_ff <= d1_basis_ff;
         d3_rnd_ff   <= d3_rnd_in;
         d3_neg_ff   <= d3_neg_in;
         d3_basis_ff <= d2_basis_ff;
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // right_x, up_y and back_z never exceed one in magnitude
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.right_x <= UNIT_ONE && rsp_item.right_x >= -UNIT_ONE &&
                     rsp_item.up_y <= UNIT_ONE && rsp_item.up_y >= -UNIT_ONE &&
                     rsp_item.back_z <= UNIT_ONE && rsp_item.back_z >= -UNIT_ONE))
      else $error("unit component out of range");

   // a degenerate forward vector zeroes the whole basis and translation
   a_zero_forward: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.back_x == 0 && rsp_item.back_y == 0 && rsp_item.back_z == 0)
      |-> (rsp_item.right_x == 0 && rsp_item.right_y == 0 && rsp_item.right_z == 0 &&
           rsp_item.shift_x == 0 && rsp_item.shift_y == 0 && rsp_item.shift_z == 0))
      else $error("nonzero output with zero forward vector");

   // a degenerate right vector forces a zero up vector
   a_zero_right: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.right_x == 0 && rsp_item.right_y == 0 && rsp_item.right_z == 0)
      |-> (rsp_item.up_x == 0 && rsp_item.up_y == 0 && rsp_item.up_z == 0 &&
           rsp_item.shift_y == 0))
      else $error("nonzero up vector with zero right vector");

endmodule

FILE: dv/look_at_view_matrix_top_tb.sv
// look_at_view_matrix_top_tb: self-checking bench for the look-at view matrix builder.
// Drives views through lavm_pkg::req_type items and checks each response against a
// bit-exact fixed-point predictor. Depends on lavm_pkg and look_at_view_matrix_top.
module look_at_view_matrix_top_tb;
   import lavm_pkg::*;

   localparam int RAND_ITEMS = 1450;
   localparam int LATENCY    = 129;
   localparam int LIMIT      = 400000;
   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;
   localparam logic signed [31:0] ONE  = 32'sh00010000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   rsp_type view_queue[$];
   int      cycles = 0;
   int      mismatches = 0;
   int      send_idle_pct = 36;
   int      recv_idle_pct = 72;

   look_at_view_matrix_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Scale all three magnitudes together so the largest sits in [2^30, 2^31).
   function automatic void unit_vector(input logic signed [63:0] v[3],
                                       output logic signed [63:0] u[3]);
      logic [63:0] m[3];
      logic [63:0] mx, sum, len, q;
      int rs, ls;
      mx = 0; sum = 0; rs = 0; ls = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return;
      end
      while (mx >= (64'd1 << 31)) begin mx = mx >> 1; rs++; end
      while (mx < (64'd1 << 30)) begin mx = mx << 1; ls++; end
      for (int i = 0; i < 3; i++) begin
         m[i] = (m[i] >> rs) << ls;
         sum  = sum + m[i] * m[i];
      end
      len = root_floor(sum);
      for (int i = 0; i < 3; i++) begin
         q    = ((m[i] << UNIT_BITS) + (len >> 1)) / len;
         u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
      end
   endfunction

   function automatic void cross_vec(input logic signed [63:0] a[3],
                                     input logic signed [63:0] b[3],
                                     output logic signed [63:0] c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   // Unit dot eye, rounded half away from zero back to Q16.16.
   function automatic logic signed [63:0] project_eye(logic signed [63:0] u[3],
                                                      logic signed [63:0] e[3]);
      logic signed [63:0] s;
      logic [63:0] r;
      s = u[0] * e[0] + u[1] * e[1] + u[2] * e[2];
      r = (magnitude(s) + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
      return s < 0 ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sh7fffffff) return MAXV;
      if (v < -64'sh80000000) return MINV;
      return v[31:0];
   endfunction

   function automatic rsp_type predict_view(req_type r);
      logic signed [63:0] eye[3], diff[3], hint[3], fwd[3], rgt[3], up[3], tmp[3];
      rsp_type o;
      eye[0] = r.eye_x; eye[1] = r.eye_y; eye[2] = r.eye_z;
      diff[0] = 64'(r.aim_x) - eye[0];
      diff[1] = 64'(r.aim_y) - eye[1];
      diff[2] = 64'(r.aim_z) - eye[2];
      hint[0] = r.hint_x; hint[1] = r.hint_y; hint[2] = r.hint_z;
      unit_vector(diff, fwd);
      cross_vec(fwd, hint, tmp);
      unit_vector(tmp, rgt);
      cross_vec(rgt, fwd, tmp);
      unit_vector(tmp, up);
      o.right_x = rgt[0][31:0]; o.right_y = rgt[1][31:0]; o.right_z = rgt[2][31:0];
      o.up_x = up[0][31:0]; o.up_y = up[1][31:0]; o.up_z = up[2][31:0];
      o.back_x = 32'(-fwd[0]); o.back_y = 32'(-fwd[1]); o.back_z = 32'(-fwd[2]);
      o.shift_x = clamp32(-project_eye(rgt, eye));
      o.shift_y = clamp32(-project_eye(up, eye));
      o.shift_z = clamp32(project_eye(fwd, eye));
      return o;
   endfunction

   // ---------------------------------------------------------------- directed table
   typedef struct {
      req_type view;
      bit      typed;   // expected response is written in the row
      rsp_type want;
   } view_row_type;

   view_row_type view_table[$];

   function automatic req_type mk(logic signed [31:0] ex, ey, ez, ax, ay, az,
                                  hx, hy, hz);
      req_type r;
      r = '{ex, ey, ez, ax, ay, az, hx, hy, hz};
      return r;
   endfunction

   task automatic add_row(req_type v, bit typed = 0, rsp_type w = '0);
      view_row_type row;
      row.view = v; row.typed = typed; row.want = w;
      view_table.push_back(row);
   endtask

   task automatic build_table();
      rsp_type w;
      // eye equals aim: everything zero
      add_row('0, 1, '0);
      add_row(mk(MAXV, MINV, ONE, MAXV, MINV, ONE, ONE, 0, 0), 1, '0);
      // forward along -z from origin, hint +y: identity basis
      w = '0;
      w.right_x = 32'sh40000000; w.up_y = 32'sh40000000; w.back_z = 32'sh40000000;
      add_row(mk(0, 0, 0, 0, 0, -ONE, 0, ONE, 0), 1, w);
      // hint zero: right and up zero, back still set
      w = '0; w.back_z = 32'sh40000000;
      add_row(mk(0, 0, 0, 0, 0, -ONE, 0, 0, 0), 1, w);
      // hint parallel to forward
      add_row(mk(0, 0, 0, 0, 0, -ONE, 0, 0, ONE), 1, w);
      add_row(mk(0, 0, 0, 0, 0, -ONE, 0, 0, MINV), 1, w);
      // field extremes and saturating translations
      add_row(mk(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV));
      add_row(mk(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MINV));
      add_row(mk(MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, MAXV, 0));
      add_row(mk(MAXV, 0, 0, MAXV, 0, -1, 0, 1, 0));
      add_row(mk(MINV, MAXV, MINV, 0, 0, 0, 1, 1, 1));
      add_row(mk(-1, -1, -1, 0, 0, 0, -1, 0, 1));
      add_row(mk(1, 0, 0, 0, 1, 0, 0, 0, -1));
      add_row(mk(32'sh12345678, -32'sh0badf00d, 32'sh00f0f0f0,
                 -32'sh7000000, 32'sh1234, 32'sh55555555, MAXV, MAXV, MAXV));
      add_row(mk(MAXV, MAXV, 0, MINV, MINV, 0, 0, 0, MINV));
      add_row(mk(0, 0, 0, 1, 1, 1, MINV, MINV, MINV));
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return MAXV;
         1: return MINV;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 2 * ONE)) - ONE);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_view();
      req_type r;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      case ($urandom_range(0, 9))
         0: begin r.aim_x = r.eye_x; r.aim_y = r.eye_y; r.aim_z = r.eye_z; end
         1: begin r.hint_x = r.aim_x - r.eye_x; r.hint_y = r.aim_y - r.eye_y;
                  r.hint_z = r.aim_z - r.eye_z; end
         2: begin r.hint_x = 0; r.hint_y = 0; r.hint_z = 0; end
         3, 4: begin
            r.eye_x = pick_word(); r.eye_y = pick_word(); r.eye_z = pick_word();
            r.aim_x = pick_word(); r.aim_y = pick_word(); r.aim_z = pick_word();
            r.hint_x = pick_word(); r.hint_y = pick_word(); r.hint_z = pick_word();
         end
         5: begin   // small scene around the origin
            r.eye_x = r.eye_x >>> 12; r.eye_y = r.eye_y >>> 12; r.eye_z = r.eye_z >>> 12;
            r.aim_x = r.aim_x >>> 12; r.aim_y = r.aim_y >>> 12; r.aim_z = r.aim_z >>> 12;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   // Present one item at the falling edge, hold it until accepted.
   task automatic send_view(req_type v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item  <= v;
      req_valid <= 1'b1;
      view_queue.push_back(predict_view(v));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic report_miss(rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: expected %h actual %h", cycles, want, got);
   endtask

   // Receiver stall pattern, changed at the falling edge.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Check every accepted response against the oldest expectation.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (view_queue.size() == 0) report_miss('0, rsp_item);
         else begin
            rsp_type want;
            want = view_queue.pop_front();
            if (rsp_item !== want) report_miss(want, rsp_item);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= LIMIT) begin
         $display("** look_at_view_matrix_top: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      view_row_type row;
      build_table();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // walk the directed table; typed rows override the predicted value
      foreach (view_table[i]) begin
         row = view_table[i];
         send_view(row.view);
         if (row.typed) view_queue[view_queue.size() - 1] = row.want;
      end
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 36; recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 36; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < RAND_ITEMS / 3; n++) send_view(random_view());
      end
      req_valid <= 1'b0;
      while (view_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && view_queue.size() == 0)
         $display("** look_at_view_matrix_top: PASSED **");
      else
         $display("** look_at_view_matrix_top: FAILED **");
      $finish;
   end
endmodule
